### rtl/ltmp_pkg.sv
// Shared types, constants and functions for the LTE TTI timing and MIB packer.
package ltmp_pkg;

    localparam int TTI_W   = 14;
    localparam int FRAME_W = 10;
    localparam int SF_W    = 4;
    localparam int CNT_W   = 32;
    localparam int BW_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [TTI_W-1:0] TTI_MOD      = 14'd10240;
    localparam logic [TTI_W-1:0] TTI_LAST     = 14'd10239;
    localparam logic [TTI_W-1:0] SF_PER_FRAME = 14'd10;
    localparam logic [TTI_W-1:0] TTI_OFFSET   = 14'd4;

    // floor(x * RECIP_10 / 2^16) == x / 10 for x below 10240
    localparam int RECIP_SHIFT = 16;
    localparam logic [12:0] RECIP_10 = 13'd6554;

    localparam logic [CFG_IDX_W-1:0] REG_DL_BANDWIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHICH_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHICH_RESOURCE = 2'd2;

    localparam logic [7:0] SFN_LOW_MASK = 8'hfc;

    typedef struct packed {
        logic [TTI_W-1:0] rx_tti;
        logic [TTI_W-1:0] ul_tti;
        logic             mib_valid;
        logic [7:0]       mib_first_byte;
        logic [7:0]       mib_second_byte;
    } tti_item_t;

    function automatic logic [2:0] bw_code(input logic [BW_W-1:0] rb);
        logic [2:0] code;
        begin
            unique case (rb)
                8'd6:    code = 3'd0;
                8'd15:   code = 3'd1;
                8'd25:   code = 3'd2;
                8'd50:   code = 3'd3;
                8'd100:  code = 3'd4;
                default: code = 3'd2;
            endcase
            return code;
        end
    endfunction

endpackage

### rtl/ltmp_front.sv
// Front end: configuration registers, TTI arithmetic and MIB byte formation.
module ltmp_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [ltmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ltmp_pkg::BW_W-1:0]          cfg_wdata,
    input  logic [ltmp_pkg::FRAME_W-1:0]       frame_number,
    input  logic [ltmp_pkg::SF_W-1:0]          subframe_number,
    output ltmp_pkg::tti_item_t                item
);

    logic [ltmp_pkg::BW_W-1:0] dl_bandwidth_reg;
    logic                      phich_duration_reg;
    logic [1:0]                phich_resource_reg;

    logic [ltmp_pkg::TTI_W-1:0] tx_raw;
    logic [ltmp_pkg::TTI_W-1:0] tx;
    logic [ltmp_pkg::TTI_W-1:0] ul_raw;
    logic                       mib_due;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_bandwidth_reg   <= 8'd25;
            phich_duration_reg <= 1'b0;
            phich_resource_reg <= 2'd0;
        end
        else if (cfg_wen)
        begin
            priority case (cfg_index)
                ltmp_pkg::REG_DL_BANDWIDTH:   dl_bandwidth_reg   <= cfg_wdata;
                ltmp_pkg::REG_PHICH_DURATION: phich_duration_reg <= cfg_wdata[0];
                ltmp_pkg::REG_PHICH_RESOURCE: phich_resource_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        tx_raw = {4'd0, frame_number} * ltmp_pkg::SF_PER_FRAME
               + {10'd0, subframe_number};
        tx = (tx_raw >= ltmp_pkg::TTI_MOD) ? tx_raw - ltmp_pkg::TTI_MOD : tx_raw;
        item.rx_tti = (tx >= ltmp_pkg::TTI_OFFSET) ? tx - ltmp_pkg::TTI_OFFSET
                    : tx + (ltmp_pkg::TTI_MOD - ltmp_pkg::TTI_OFFSET);
        ul_raw = tx + ltmp_pkg::TTI_OFFSET;
        item.ul_tti = (ul_raw >= ltmp_pkg::TTI_MOD) ? ul_raw - ltmp_pkg::TTI_MOD : ul_raw;

        mib_due = (subframe_number == 4'd0) && (frame_number[1:0] == 2'd0);
        item.mib_valid = mib_due;
        item.mib_first_byte  = 8'd0;
        item.mib_second_byte = 8'd0;
        if (mib_due)
        begin
            item.mib_first_byte = {ltmp_pkg::bw_code(dl_bandwidth_reg), phich_duration_reg,
                                   phich_resource_reg, frame_number[9:8]};
            item.mib_second_byte = frame_number[7:0] & ltmp_pkg::SFN_LOW_MASK;
        end
    end

endmodule

### rtl/ltmp_queue.sv
// Small FIFO between the front end and the back end.
module ltmp_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ltmp_pkg::tti_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output ltmp_pkg::tti_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ltmp_pkg::tti_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not shrink on pop");

endmodule

### rtl/ltmp_back.sv
// Back end: absolute TTI counters, frame/subframe split and output register.
module ltmp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ltmp_pkg::tti_item_t head_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [135:0]        m_tdata,
    output logic                m_tuser
);

    logic [ltmp_pkg::CNT_W-1:0] abs_tx_counter_reg, abs_tx_counter_next;
    logic [ltmp_pkg::TTI_W-1:0] abs_tx_wrapped_reg;
    logic [ltmp_pkg::CNT_W-1:0] abs_rx_counter_reg, abs_rx_counter_next;
    logic [ltmp_pkg::TTI_W-1:0] abs_rx_wrapped_reg;
    logic [ltmp_pkg::TTI_W-1:0] tx_tti;
    logic [ltmp_pkg::TTI_W-1:0] tx_follow;
    logic [ltmp_pkg::TTI_W-1:0] rx_follow;

    logic [26:0] rx_prod, ul_prod;
    logic [ltmp_pkg::TTI_W-1:0] rx_q, ul_q, rx_rem, ul_rem;

    logic         out_valid_reg;
    logic [135:0] out_data_reg, out_data_next;
    logic         out_user_reg;

    assign pop = head_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        // transmit TTI recovered from the uplink TTI, four ahead of it
        tx_tti = (head_item.ul_tti >= ltmp_pkg::TTI_OFFSET)
               ? head_item.ul_tti - ltmp_pkg::TTI_OFFSET
               : head_item.ul_tti + (ltmp_pkg::TTI_MOD - ltmp_pkg::TTI_OFFSET);
        tx_follow = (abs_tx_wrapped_reg == ltmp_pkg::TTI_LAST) ? '0 : abs_tx_wrapped_reg + 1'b1;
        rx_follow = (abs_rx_wrapped_reg == ltmp_pkg::TTI_LAST) ? '0 : abs_rx_wrapped_reg + 1'b1;
        abs_tx_counter_next = (tx_tti == tx_follow) ? abs_tx_counter_reg + 1'b1
                            : {18'd0, tx_tti};
        abs_rx_counter_next = (head_item.rx_tti == rx_follow) ? abs_rx_counter_reg + 1'b1
                            : {18'd0, head_item.rx_tti};

        rx_prod = head_item.rx_tti * ltmp_pkg::RECIP_10;
        ul_prod = head_item.ul_tti * ltmp_pkg::RECIP_10;
        rx_q = {3'd0, rx_prod[26:ltmp_pkg::RECIP_SHIFT]};
        ul_q = {3'd0, ul_prod[26:ltmp_pkg::RECIP_SHIFT]};
        rx_rem = head_item.rx_tti - ((rx_q << 3) + (rx_q << 1));
        ul_rem = head_item.ul_tti - ((ul_q << 3) + (ul_q << 1));

        out_data_next = {head_item.mib_second_byte, head_item.mib_first_byte,
                         abs_rx_counter_next, abs_tx_counter_next,
                         ul_rem[3:0], ul_q[9:0], head_item.ul_tti,
                         rx_rem[3:0], rx_q[9:0], head_item.rx_tti};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_tx_counter_reg <= '0;
            abs_tx_wrapped_reg <= '0;
            abs_rx_counter_reg <= '0;
            abs_rx_wrapped_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                abs_tx_counter_reg <= abs_tx_counter_next;
                abs_tx_wrapped_reg <= tx_tti;
                abs_rx_counter_reg <= abs_rx_counter_next;
                abs_rx_wrapped_reg <= head_item.rx_tti;
                out_valid_reg      <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= head_item.mib_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !out_valid_reg || m_tready)
        else $error("pop while output register occupied");

    a_pop_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped request not presented");

    a_wrapped_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        abs_tx_wrapped_reg < ltmp_pkg::TTI_MOD && abs_rx_wrapped_reg < ltmp_pkg::TTI_MOD)
        else $error("stored TTI out of range");

endmodule

### rtl/lte_tti_timing_and_mib_packer_top.sv
// Top level of the LTE TTI timing and MIB packer.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one request per downlink TTI: the frame
//   number and subframe number. m_tvalid/m_tready/m_tdata/m_tuser return one
//   result per request: receive and uplink TTIs with their frame/subframe
//   split, the absolute transmit and receive counters, and the two leading
//   MIB bytes; m_tuser flags subframe 0 of every fourth frame.
//   The configuration port (cfg_wen, cfg_index, cfg_wdata) sets bandwidth,
//   PHICH duration and PHICH resource; write it only while no request is
//   in flight.
// Timing:
//   An accepted request is written into the queue and then loaded into the
//   output register, which drives m_tvalid.
//   One request per cycle is sustained while m_tready stays high; the single
//   multiply per path in the back end sets the clock.
// Reset and stalls:
//   Reset empties the queue and output register, zeroes both counters and
//   restores bandwidth 25 RB with PHICH fields zero. When m_tready is low
//   the output holds, the queue fills, and s_tready drops once it is full.
module lte_tti_timing_and_mib_packer_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // frame_number[9:0], subframe_number[13:10], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    // rx_tti[13:0], rx_frame[23:14], rx_subframe[27:24], ul_tti[41:28],
    // ul_frame[51:42], ul_subframe[55:52], abs_tx_count[87:56],
    // abs_rx_count[119:88], mib_first_byte[127:120], mib_second_byte[135:128]
    output logic [135:0] m_tdata,
    output logic         m_tuser,   // mib_valid
    input  logic         cfg_wen,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata
);

    ltmp_pkg::tti_item_t front_item;
    ltmp_pkg::tti_item_t head_item;
    logic q_full;
    logic q_head_valid;
    logic q_pop;
    logic push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    ltmp_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .frame_number    (s_tdata[9:0]),
        .subframe_number (s_tdata[13:10]),
        .item            (front_item)
    );

    ltmp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (head_item)
    );

    ltmp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
